[hw/rtl/cpma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cpma_pkg;

	localparam int LANES          = 4;
	localparam int FEATURE_BITS   = 16;
	localparam int MATRIX_MAX_DEF = 32;
	localparam int VALUE_BITS     = 48;
	localparam int WIDE_BITS      = 52;
	localparam int PROD_BITS      = 2 * FEATURE_BITS;
	localparam int COS_FRAC       = 26;
	localparam int ROOT_BITS      = 32;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic signed [WIDE_BITS-1:0]  wide_t;

	localparam value_t ONE_Q26 = value_t'(1) <<< COS_FRAC;
	localparam wide_t WIDE_VMAX = {{(WIDE_BITS-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
	localparam wide_t WIDE_VMIN = {{(WIDE_BITS-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_FEAT   = 2'd0,
		OP_ASSIGN = 2'd1,
		OP_TRACE  = 2'd2,
		OP_MEAN   = 2'd3
	} op_t;

	localparam logic [1:0] METRIC_DOT = 2'd0;
	localparam logic [1:0] METRIC_L2  = 2'd1;
	localparam logic [1:0] METRIC_COS = 2'd2;

	localparam logic REG_METRIC = 1'b0;
	localparam logic REG_SIZE   = 1'b1;

	typedef struct packed {
		logic   sat;
		value_t val;
	} sat_t;

	typedef struct packed {
		logic signed [PROD_BITS-1:0] dot;
		logic signed [PROD_BITS-1:0] tn;
		logic signed [PROD_BITS-1:0] bn;
	} lane_prod_t;

	// Sign-extend a stored value for exact intermediate sums
	function automatic wide_t wide(input value_t v);
		return WIDE_BITS'(v);
	endfunction

	// Clip to the signed 48-bit range and flag a clip
	function automatic sat_t sat48(input wide_t x);
		sat_t s;
		if (x > WIDE_VMAX) begin
			s.sat = 1'b1;
			s.val = {1'b0, {(VALUE_BITS-1){1'b1}}};
		end else if (x < WIDE_VMIN) begin
			s.sat = 1'b1;
			s.val = {1'b1, {(VALUE_BITS-1){1'b0}}};
		end else begin
			s.sat = 1'b0;
			s.val = x[VALUE_BITS-1:0];
		end
		return s;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/cpma_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
module cpma_lane import cpma_pkg::*; (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic signed [FEATURE_BITS-1:0] a,
	input  wire logic signed [FEATURE_BITS-1:0] b,
	output lane_prod_t                          prod_s1
);

	// Form cross and square products of one lane on transfer
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.dot <= a * b;
			prod_s1.tn  <= a * a;
			prod_s1.bn  <= b * b;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/cpma_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
module cpma_isqrt import cpma_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [63:0]          x,
	output logic                      done,
	output logic [ROOT_BITS-1:0]      root
);

	logic [63:0] x_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic        run_q;
	logic [63:0] trial;

	assign trial = r_q + bit_q;
	assign root  = r_q[ROOT_BITS-1:0];

	// Resolve one result bit per step, floor of the square root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			r_q   <= '0;
			bit_q <= '0;
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				x_q   <= x;
				r_q   <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (x_q >= trial) begin
					x_q <= x_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/pairwise_cost_matrix_accumulator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pairwise cost matrix accumulator. Holds a MATRIX_MAX x MATRIX_MAX store of
// Q22.26 costs. An item is taken when start is high and busy is low; each
// result appears on value/saturated for one cycle with done high, and the
// receiver cannot stall it. After reset a clearing pass writes zero to all
// MATRIX_MAX*MATRIX_MAX cells with busy high; register writes are taken
// meanwhile. Per item, the lane merge adds the four lane products into the
// running sums one lane a cycle, and the store has a single read port. A
// last feature item then computes the dot or L2 metric, or the cosine
// (two 32-step square roots, one multiply, a 26-step divide), and updates
// its cell by a read and a write. Assignment entries read one cell, a trace
// query walks the n diagonal cells and a mean query all n*n cells and then
// divides by n, with n the effective matrix size.
module pairwise_cost_matrix_accumulator import cpma_pkg::*; #(
	parameter int MATRIX_MAX = MATRIX_MAX_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     op,
	input  wire logic [4:0]                     row,
	input  wire logic [4:0]                     col,
	input  wire logic signed [FEATURE_BITS-1:0] target_lane0,
	input  wire logic signed [FEATURE_BITS-1:0] target_lane1,
	input  wire logic signed [FEATURE_BITS-1:0] target_lane2,
	input  wire logic signed [FEATURE_BITS-1:0] target_lane3,
	input  wire logic signed [FEATURE_BITS-1:0] base_lane0,
	input  wire logic signed [FEATURE_BITS-1:0] base_lane1,
	input  wire logic signed [FEATURE_BITS-1:0] base_lane2,
	input  wire logic signed [FEATURE_BITS-1:0] base_lane3,
	input  wire logic                           last,
	output logic                                done,
	output value_t                              value,
	output logic                                saturated,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [2:0]                     paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int DEPTH = MATRIX_MAX * MATRIX_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MERGE, S_FIN, S_SQRT, S_MUL, S_DSET, S_DIV,
		S_CEND, S_CELL_RD, S_CELL_WR, S_ASG_RD, S_ASG_ADD, S_WALK, S_MDIV, S_MEND
	} state_t;

	state_t                state_q;
	logic [1:0]            metric_q;
	logic [5:0]            size_q;
	op_t                   op_q;
	logic [4:0]            row_q;
	logic [4:0]            col_q;
	logic                  last_q;
	logic                  inside_q;
	logic [LW-1:0]         lane_q;
	value_t                dot_q;
	value_t                tn_q;
	value_t                bn_q;
	logic                  vsat_q;
	value_t                asg_q;
	logic                  psat_q;
	value_t                contrib_q;
	logic                  csat_q;
	logic [63:0]           d_q;
	logic [63:0]           cr_q;
	logic [COS_FRAC:0]     cq_q;
	logic [5:0]            cnt_q;
	value_t                acc_q;
	logic                  asat_q;
	logic [5:0]            wi_q;
	logic [5:0]            wj_q;
	logic                  rdv_q;
	logic [AW-1:0]         clr_q;
	logic                  neg_q;
	logic [5:0]            rem_q;
	logic [VALUE_BITS-1:0] mq_q;
	value_t                rd_q;

	logic                           accept;
	logic [5:0]                     n_eff;
	logic                           in_range;
	logic signed [FEATURE_BITS-1:0] ta [LANES];
	logic signed [FEATURE_BITS-1:0] tb [LANES];
	lane_prod_t                     prods [LANES];
	lane_prod_t                     prod_sel;
	logic [AW-1:0]                  cell_idx;
	logic [AW-1:0]                  walk_idx;
	logic [AW-1:0]                  rd_addr;
	logic                           mem_we;
	logic [AW-1:0]                  mem_wa;
	value_t                         mem_wd;
	sat_t                           m_dot;
	sat_t                           m_tn;
	sat_t                           m_bn;
	sat_t                           l2;
	sat_t                           negdot;
	sat_t                           cell_sum;
	sat_t                           asg_sum;
	sat_t                           acc_sum;
	logic                           sq_start;
	logic                           sqa_done;
	logic                           sqb_done;
	logic [ROOT_BITS-1:0]           root_a;
	logic [ROOT_BITS-1:0]           root_b;
	logic [63:0]                    dmr;
	logic                           cge;
	logic [63:0]                    dmag;
	logic [63:0]                    numf;
	logic [63:0]                    numc;
	logic                           issue;
	logic [6:0]                     rem_sh;
	logic                           mge;
	logic [6:0]                     rem_nx;
	logic [VALUE_BITS-1:0]          amag;

	value_t mem [DEPTH];

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign pready = 1'b1;

	// Clamp the configured size to the store
	assign n_eff    = (int'(size_q) > MATRIX_MAX) ? 6'(MATRIX_MAX) : size_q;
	assign in_range = ({1'b0, row} < n_eff) && ({1'b0, col} < n_eff);

	// Register readback
	assign prdata = (paddr[2] == REG_SIZE) ? {26'd0, size_q} : {30'd0, metric_q};

	// Gather lane inputs
	assign ta[0] = target_lane0;
	assign ta[1] = target_lane1;
	assign ta[2] = target_lane2;
	assign ta[3] = target_lane3;
	assign tb[0] = base_lane0;
	assign tb[1] = base_lane1;
	assign tb[2] = base_lane2;
	assign tb[3] = base_lane3;

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		cpma_lane u_lane (
			.clk     (clk),
			.en      (accept),
			.a       (ta[k]),
			.b       (tb[k]),
			.prod_s1 (prods[k])
		);
	end

	assign prod_sel = prods[lane_q];

	// Merge one lane into the running sums
	assign m_dot = sat48(wide(dot_q) + WIDE_BITS'(prod_sel.dot));
	assign m_tn  = sat48(wide(tn_q) + WIDE_BITS'(prod_sel.tn));
	assign m_bn  = sat48(wide(bn_q) + WIDE_BITS'(prod_sel.bn));

	// Metric candidates
	assign l2     = sat48(wide(tn_q) + wide(bn_q) - (wide(dot_q) <<< 1));
	assign negdot = sat48(-wide(dot_q));

	// Store addressing
	assign cell_idx = AW'(int'(row_q) * MATRIX_MAX + int'(col_q));
	assign walk_idx = AW'(int'(wi_q) * MATRIX_MAX + int'(wj_q));
	assign rd_addr  = (state_q == S_WALK) ? walk_idx : cell_idx;

	assign cell_sum = sat48(wide(rd_q) + wide(contrib_q));
	assign asg_sum  = sat48(wide(asg_q) + wide(rd_q));
	assign acc_sum  = sat48(wide(acc_q) + wide(rd_q));

	assign mem_we = (state_q == S_CLEAR) || (state_q == S_CELL_WR);
	assign mem_wa = (state_q == S_CLEAR) ? clr_q : cell_idx;
	assign mem_wd = (state_q == S_CLEAR) ? '0 : cell_sum.val;

	// Cost store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[rd_addr];
	end

	// Square roots of both norms scaled by 2^16, giving roots scaled by 2^8
	assign sq_start = (state_q == S_FIN) && (metric_q == METRIC_COS);

	cpma_isqrt u_sqrt_t (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      ({tn_q, 16'd0}),
		.done   (sqa_done),
		.root   (root_a)
	);

	cpma_isqrt u_sqrt_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      ({bn_q, 16'd0}),
		.done   (sqb_done),
		.root   (root_b)
	);

	// Cosine ratio step and numerator setup
	assign dmr  = d_q - cr_q;
	assign cge  = (cr_q >= dmr);
	assign dmag = dot_q[VALUE_BITS-1] ? 64'(-wide(dot_q)) : 64'(dot_q);
	assign numf = dmag << 16;
	assign numc = (numf > d_q) ? d_q : numf;

	// Walk issue and mean division step
	assign issue  = (wi_q < n_eff);
	assign rem_sh = {rem_q, mq_q[VALUE_BITS-1]};
	assign mge    = (rem_sh >= {1'b0, n_eff});
	assign rem_nx = mge ? (rem_sh - {1'b0, n_eff}) : rem_sh;
	assign amag   = acc_q[VALUE_BITS-1] ? VALUE_BITS'(-acc_q) : VALUE_BITS'(acc_q);

	// Control sequencer, accumulators and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			metric_q  <= '0;
			size_q    <= '0;
			op_q      <= OP_FEAT;
			row_q     <= '0;
			col_q     <= '0;
			last_q    <= 1'b0;
			inside_q  <= 1'b0;
			lane_q    <= '0;
			dot_q     <= '0;
			tn_q      <= '0;
			bn_q      <= '0;
			vsat_q    <= 1'b0;
			asg_q     <= '0;
			psat_q    <= 1'b0;
			contrib_q <= '0;
			csat_q    <= 1'b0;
			d_q       <= '0;
			cr_q      <= '0;
			cq_q      <= '0;
			cnt_q     <= '0;
			acc_q     <= '0;
			asat_q    <= 1'b0;
			wi_q      <= '0;
			wj_q      <= '0;
			rdv_q     <= 1'b0;
			clr_q     <= '0;
			neg_q     <= 1'b0;
			rem_q     <= '0;
			mq_q      <= '0;
			done      <= 1'b0;
			value     <= '0;
			saturated <= 1'b0;
		end else begin
			done <= 1'b0;

			// Register write on the access phase
			if (psel && penable && pwrite) begin
				case (paddr[2])
					REG_METRIC: metric_q <= pwdata[1:0];
					REG_SIZE:   size_q   <= pwdata[5:0];
					default:    ;
				endcase
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q     <= op_t'(op);
						row_q    <= row;
						col_q    <= col;
						last_q   <= last;
						inside_q <= in_range;
						case (op_t'(op))
							OP_FEAT: begin
								if (in_range) begin
									lane_q  <= '0;
									state_q <= S_MERGE;
								end else if (last) begin
									dot_q  <= '0;
									tn_q   <= '0;
									bn_q   <= '0;
									vsat_q <= 1'b0;
								end
							end
							OP_ASSIGN: state_q <= S_ASG_RD;
							default: begin
								acc_q   <= '0;
								asat_q  <= 1'b0;
								wi_q    <= '0;
								wj_q    <= '0;
								rdv_q   <= 1'b0;
								state_q <= S_WALK;
							end
						endcase
					end
				end
				S_MERGE: begin
					dot_q  <= m_dot.val;
					tn_q   <= m_tn.val;
					bn_q   <= m_bn.val;
					vsat_q <= vsat_q | m_dot.sat | m_tn.sat | m_bn.sat;
					lane_q <= lane_q + 1'b1;
					if (lane_q == LW'(LANES - 1)) begin
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					case (metric_q)
						METRIC_L2: begin
							contrib_q <= l2.val;
							csat_q    <= vsat_q | l2.sat;
							state_q   <= S_CELL_RD;
						end
						METRIC_COS: begin
							csat_q  <= vsat_q;
							state_q <= S_SQRT;
						end
						default: begin
							contrib_q <= negdot.val;
							csat_q    <= vsat_q | negdot.sat;
							state_q   <= S_CELL_RD;
						end
					endcase
				end
				S_SQRT: begin
					if (sqa_done && sqb_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					d_q     <= 64'(root_a) * 64'(root_b);
					state_q <= S_DSET;
				end
				S_DSET: begin
					if (d_q == '0) begin
						contrib_q <= ONE_Q26;
						state_q   <= S_CELL_RD;
					end else begin
						cq_q    <= (numc == d_q) ? (COS_FRAC+1)'(1) : '0;
						cr_q    <= (numc == d_q) ? '0 : numc;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cq_q  <= {cq_q[COS_FRAC-1:0], cge};
					cr_q  <= cge ? (cr_q - dmr) : (cr_q << 1);
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'(COS_FRAC - 1)) begin
						state_q <= S_CEND;
					end
				end
				S_CEND: begin
					contrib_q <= dot_q[VALUE_BITS-1] ? (ONE_Q26 + VALUE_BITS'(cq_q))
					                                 : (ONE_Q26 - VALUE_BITS'(cq_q));
					state_q   <= S_CELL_RD;
				end
				S_CELL_RD: state_q <= S_CELL_WR;
				S_CELL_WR: begin
					value     <= cell_sum.val;
					saturated <= csat_q | cell_sum.sat;
					done      <= 1'b1;
					dot_q     <= '0;
					tn_q      <= '0;
					bn_q      <= '0;
					vsat_q    <= 1'b0;
					state_q   <= S_IDLE;
				end
				S_ASG_RD: state_q <= S_ASG_ADD;
				S_ASG_ADD: begin
					if (last_q) begin
						value     <= inside_q ? asg_sum.val : asg_q;
						saturated <= psat_q | (inside_q & asg_sum.sat);
						done      <= 1'b1;
						asg_q     <= '0;
						psat_q    <= 1'b0;
					end else if (inside_q) begin
						asg_q  <= asg_sum.val;
						psat_q <= psat_q | asg_sum.sat;
					end
					state_q <= S_IDLE;
				end
				S_WALK: begin
					rdv_q <= issue;
					if (issue) begin
						if (op_q == OP_TRACE) begin
							wi_q <= wi_q + 1'b1;
							wj_q <= wj_q + 1'b1;
						end else if (wj_q == n_eff - 1'b1) begin
							wj_q <= '0;
							wi_q <= wi_q + 1'b1;
						end else begin
							wj_q <= wj_q + 1'b1;
						end
					end
					if (rdv_q) begin
						acc_q  <= acc_sum.val;
						asat_q <= asat_q | acc_sum.sat;
					end
					if (!issue && !rdv_q) begin
						if (op_q == OP_TRACE || n_eff == '0) begin
							value     <= acc_q;
							saturated <= asat_q;
							done      <= 1'b1;
							state_q   <= S_IDLE;
						end else begin
							neg_q   <= acc_q[VALUE_BITS-1];
							mq_q    <= amag;
							rem_q   <= '0;
							cnt_q   <= '0;
							state_q <= S_MDIV;
						end
					end
				end
				S_MDIV: begin
					rem_q <= rem_nx[5:0];
					mq_q  <= {mq_q[VALUE_BITS-2:0], mge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'(VALUE_BITS - 1)) begin
						state_q <= S_MEND;
					end
				end
				S_MEND: begin
					value     <= neg_q ? -value_t'(mq_q) : value_t'(mq_q);
					saturated <= asat_q;
					done      <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
